// ----- rtl/core/pop_pkg.sv -----
// Shared types and constants for the partitioned object pool.
// Used by pop_seq and partitioned_object_pool; no dependencies.
package pop_pkg;

  localparam int REG_COUNT = 6;
  localparam int CNT_W     = 8;
  localparam int BASE_W    = 12;
  localparam int CLS_W     = 3;
  localparam int SLOT_IN_W = 7;
  localparam int CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0] CNT_RESET [REG_COUNT] = '{
    8'd8, 8'd8, 8'd16, 8'd32, 8'd32, 8'd32
  };

  typedef enum logic [1:0] {
    ACT_INIT    = 2'd0,
    ACT_ALLOC   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_WALK    = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_EMPTY    = 2'd1,
    STS_NOT_USED = 2'd2,
    STS_OVER     = 2'd3
  } stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_BASE,
    S_CHECK,
    S_FILL,
    S_ALLOC_A,
    S_ALLOC_B,
    S_LOOKUP,
    S_REL_A,
    S_REL_B,
    S_WALK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic cls_bad;
    act_t act;
    logic from_head;
    logic s_bad;
    logic f_nil;
    logic base_done;
    logic over;
    logic cnt_zero;
    logic fill_last;
    logic owner_bad;
  } cond_t;

  typedef struct packed {
    logic in_ready;
    logic capture;
    logic decode;
    logic base_step;
    logic check;
    logic fill;
    logic alloc_a;
    logic alloc_b;
    logic lookup;
    logic rel_a;
    logic rel_b;
    logic walk;
    logic resp_load;
  } ctl_t;

endpackage

// ----- rtl/core/partitioned_object_pool.sv -----
// Init adds up the base of the class one base term at a time, checks the class end against
// the pool, then fills the class one slot per cycle.
// Throughput: one transaction at a time; the next can be taken in the cycle after the result
// is loaded. Link, prev and owner stores sit in RAMs with one write and one read port each.
// Synchronous active-low reset: all classes empty and uninitialized, no slot busy,
// slot counts back to 8, 8, 16, 32, 32, 32. Link stores are not cleared.
module partitioned_object_pool #(
  parameter int POOL_SLOTS  = 128,
  parameter int NUM_CLASSES = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [2:0] in_pool_class,
  input  logic [6:0] in_slot,
  input  logic       in_from_head,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_result_slot,
  output logic [1:0] out_status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int SLOT_W = $clog2(POOL_SLOTS);
  localparam int LINK_W = $clog2(POOL_SLOTS + 1);
  localparam int CIDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_SLOTS);

  localparam int BW = pop_pkg::BASE_W;
  localparam int CW = pop_pkg::CLS_W;
  localparam int SW = pop_pkg::SLOT_IN_W;

  pop_pkg::cond_t cond;
  pop_pkg::ctl_t  ctl;

  pop_pkg::act_t            act_r;
  logic [CW-1:0]            cls_r;
  logic [SW-1:0]            slot_r;
  logic                     from_head_r;
  logic [pop_pkg::CNT_W-1:0] cnt_r [pop_pkg::REG_COUNT];

  logic [BW-1:0]            acc_r;
  logic [BW-1:0]            end_r;
  logic [CW-1:0]            k_r;
  logic [SLOT_W-1:0]        f_r;
  logic [LINK_W-1:0]        u_r;
  logic [SW-1:0]            res_slot_r;
  pop_pkg::stat_t           res_st_r;
  logic                     out_valid_r;
  logic [SW-1:0]            out_slot_r;
  pop_pkg::stat_t           out_st_r;

  logic [POOL_SLOTS-1:0]    busy_r;
  logic [LINK_W-1:0]        free_head_r [NUM_CLASSES];
  logic [LINK_W-1:0]        used_head_r [NUM_CLASSES];

  logic                     cls_ok;
  logic [CIDX_W-1:0]        ci;
  logic [LINK_W-1:0]        fh;
  logic [LINK_W-1:0]        uh;
  logic                     s_ok;
  logic [SLOT_W-1:0]        si;
  logic [pop_pkg::CNT_W-1:0] cnt_k;
  logic [BW-1:0]            add_b;
  logic [BW-1:0]            sum;
  logic                     p_ok;
  logic                     n_ok;

  logic [LINK_W-1:0]        nx_rd;
  logic [LINK_W-1:0]        pv_rd;
  logic [CW-1:0]            own_rd;

  logic                     nx_we;
  logic [SLOT_W-1:0]        nx_wa;
  logic [LINK_W-1:0]        nx_wd;
  logic [SLOT_W-1:0]        nx_ra;
  logic                     pv_we;
  logic [SLOT_W-1:0]        pv_wa;
  logic [LINK_W-1:0]        pv_wd;

  logic                     free_we;
  logic [LINK_W-1:0]        free_wd;
  logic                     used_we;
  logic [LINK_W-1:0]        used_wd;
  logic                     busy_we;
  logic [SLOT_W-1:0]        busy_wa;
  logic                     busy_wd;

  logic [SW-1:0]            res_slot_nxt;
  pop_pkg::stat_t           res_st_nxt;

  // ---- decode of the held transaction ----
  assign cls_ok = (CW + 1)'(cls_r) < (CW + 1)'(NUM_CLASSES);
  assign ci     = cls_ok ? CIDX_W'(cls_r) : '0;
  assign fh     = free_head_r[ci];
  assign uh     = used_head_r[ci];
  assign s_ok   = 32'(slot_r) < 32'(POOL_SLOTS);
  assign si     = SLOT_W'(slot_r);
  assign cnt_k  = (k_r < CW'(pop_pkg::REG_COUNT)) ? cnt_r[k_r] : '0;
  assign p_ok   = pv_rd < NIL;
  assign n_ok   = nx_rd < NIL;

  // shared adder: base accumulation, class end, fill address step
  assign add_b = ctl.fill ? BW'(1) : BW'(cnt_k);
  assign sum   = acc_r + add_b;

  always_comb begin
    cond           = '0;
    cond.in_valid  = in_valid;
    cond.out_free  = !out_valid_r || out_ready;
    cond.cls_bad   = !cls_ok;
    cond.act       = act_r;
    cond.from_head = from_head_r;
    cond.s_bad     = !s_ok || !busy_r[si];
    cond.f_nil     = !(fh < NIL);
    cond.base_done = (k_r == cls_r);
    cond.over      = sum > BW'(POOL_SLOTS);
    cond.cnt_zero  = (cnt_k == '0);
    cond.fill_last = (sum == end_r);
    cond.owner_bad = (own_rd != cls_r);
  end

  pop_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cond  (cond),
    .ctl   (ctl)
  );

  // ---- configuration ----
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pop_pkg::REG_COUNT; i++) begin
        cnt_r[i] <= pop_pkg::CNT_RESET[i];
      end
    end else if (cfg_valid && cfg_index < pop_pkg::CFG_IDX_W'(pop_pkg::REG_COUNT)) begin
      cnt_r[cfg_index] <= cfg_data;
    end
  end

  // ---- transaction capture and working registers ----
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      act_r       <= pop_pkg::act_t'(in_action);
      cls_r       <= in_pool_class;
      slot_r      <= in_slot;
      from_head_r <= in_from_head;
    end
    if (ctl.decode) begin
      acc_r <= '0;
      k_r   <= '0;
      f_r   <= SLOT_W'(fh);
      u_r   <= uh;
    end
    if (ctl.base_step && !cond.base_done) begin
      acc_r <= sum;
      k_r   <= CW'(k_r + 1'b1);
    end
    if (ctl.check) begin
      end_r <= sum;
    end
    if (ctl.fill) begin
      acc_r <= sum;
    end
    res_slot_r <= res_slot_nxt;
    res_st_r   <= res_st_nxt;
  end

  // ---- result selection ----
  always_comb begin
    res_slot_nxt = res_slot_r;
    res_st_nxt   = res_st_r;
    if (ctl.decode) begin
      res_slot_nxt = '0;
      res_st_nxt   = pop_pkg::STS_OK;
      if (!cls_ok) begin
        res_st_nxt = pop_pkg::STS_EMPTY;
      end else begin
        case (act_r)
          pop_pkg::ACT_ALLOC: begin
            if (cond.f_nil) res_st_nxt = pop_pkg::STS_EMPTY;
          end
          pop_pkg::ACT_RELEASE: begin
            if (cond.s_bad) res_st_nxt = pop_pkg::STS_NOT_USED;
          end
          pop_pkg::ACT_WALK: begin
            if (from_head_r) begin
              if (uh < NIL) res_slot_nxt = SW'(uh);
              else          res_st_nxt   = pop_pkg::STS_EMPTY;
            end else if (cond.s_bad) begin
              res_st_nxt = pop_pkg::STS_NOT_USED;
            end
          end
          default: ;
        endcase
      end
    end
    if (ctl.check && cond.over) begin
      res_st_nxt = pop_pkg::STS_OVER;
    end
    if (ctl.alloc_b) begin
      res_slot_nxt = SW'(f_r);
    end
    if (ctl.rel_a && cond.owner_bad) begin
      res_st_nxt = pop_pkg::STS_NOT_USED;
    end
    if (ctl.walk) begin
      if (cond.owner_bad)  res_st_nxt   = pop_pkg::STS_NOT_USED;
      else if (!n_ok)      res_st_nxt   = pop_pkg::STS_EMPTY;
      else                 res_slot_nxt = SW'(nx_rd);
    end
  end

  // ---- link stores ----
  always_comb begin
    nx_we = 1'b0;
    nx_wa = si;
    nx_wd = fh;
    if (ctl.fill) begin
      nx_we = 1'b1;
      nx_wa = SLOT_W'(acc_r);
      nx_wd = cond.fill_last ? NIL : LINK_W'(sum);
    end else if (ctl.alloc_b) begin
      nx_we = 1'b1;
      nx_wa = f_r;
      nx_wd = u_r;
    end else if (ctl.rel_a) begin
      nx_we = !cond.owner_bad && p_ok;
      nx_wa = SLOT_W'(pv_rd);
      nx_wd = nx_rd;
    end else if (ctl.rel_b) begin
      nx_we = 1'b1;
    end
  end

  assign nx_ra = ctl.alloc_a ? f_r : si;

  always_comb begin
    pv_we = 1'b0;
    pv_wa = f_r;
    pv_wd = NIL;
    if (ctl.alloc_a) begin
      pv_we = u_r < NIL;
      pv_wa = SLOT_W'(u_r);
      pv_wd = LINK_W'(f_r);
    end else if (ctl.alloc_b) begin
      pv_we = 1'b1;
    end else if (ctl.rel_a) begin
      pv_we = !cond.owner_bad && n_ok;
      pv_wa = SLOT_W'(nx_rd);
      pv_wd = pv_rd;
    end
  end

  pop_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SLOTS)) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_wa),
    .wdata (nx_wd),
    .raddr (nx_ra),
    .rdata (nx_rd)
  );

  pop_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SLOTS)) u_prev_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_wa),
    .wdata (pv_wd),
    .raddr (si),
    .rdata (pv_rd)
  );

  pop_ram #(.WIDTH(CW), .DEPTH(POOL_SLOTS)) u_owner_ram (
    .clk   (clk),
    .we    (ctl.fill),
    .waddr (SLOT_W'(acc_r)),
    .wdata (cls_r),
    .raddr (si),
    .rdata (own_rd)
  );

  // ---- list heads ----
  always_comb begin
    free_we = 1'b0;
    free_wd = NIL;
    used_we = 1'b0;
    used_wd = NIL;
    if (ctl.check && !cond.over) begin
      free_we = 1'b1;
      free_wd = cond.cnt_zero ? NIL : LINK_W'(acc_r);
      used_we = 1'b1;
    end else if (ctl.alloc_b) begin
      free_we = 1'b1;
      free_wd = nx_rd;
      used_we = 1'b1;
      used_wd = LINK_W'(f_r);
    end else if (ctl.rel_a) begin
      used_we = !cond.owner_bad && !p_ok;
      used_wd = nx_rd;
    end else if (ctl.rel_b) begin
      free_we = 1'b1;
      free_wd = LINK_W'(si);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        free_head_r[i] <= NIL;
        used_head_r[i] <= NIL;
      end
    end else begin
      if (free_we) free_head_r[ci] <= free_wd;
      if (used_we) used_head_r[ci] <= used_wd;
    end
  end

  // ---- busy flags ----
  always_comb begin
    busy_we = 1'b0;
    busy_wa = si;
    busy_wd = 1'b0;
    if (ctl.fill) begin
      busy_we = 1'b1;
      busy_wa = SLOT_W'(acc_r);
    end else if (ctl.alloc_b) begin
      busy_we = 1'b1;
      busy_wa = f_r;
      busy_wd = 1'b1;
    end else if (ctl.rel_b) begin
      busy_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else if (busy_we) begin
      busy_r[busy_wa] <= busy_wd;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.resp_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (ctl.resp_load) begin
      out_slot_r <= res_slot_r;
      out_st_r   <= res_st_r;
    end
  end

  assign in_ready        = ctl.in_ready;
  assign out_valid       = out_valid_r;
  assign out_result_slot = out_slot_r;
  assign out_status      = out_st_r;

  // ---- assertions ----
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new transaction taken while one is in flight");

  a_result_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.resp_load))
    else $error("result shown without a response phase");

  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fill |-> (acc_r < end_r) && (acc_r < BW'(POOL_SLOTS)))
    else $error("init fill address outside class range");

  a_alloc_marks_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.alloc_b |=> busy_r[$past(f_r)])
    else $error("allocated slot not marked busy");

endmodule

// ----- rtl/core/pop_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pop_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/pop_seq.sv -----
// Sequencer for the object pool: steps each transaction through its phases.
// Depends on pop_pkg (state_t, cond_t, ctl_t, act_t).
module pop_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  pop_pkg::cond_t cond,
  output pop_pkg::ctl_t  ctl
);

  pop_pkg::state_t state_r;
  pop_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pop_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pop_pkg::S_IDLE: begin
        if (cond.in_valid) state_nxt = pop_pkg::S_DECODE;
      end
      pop_pkg::S_DECODE: begin
        if (cond.cls_bad) begin
          state_nxt = pop_pkg::S_RESP;
        end else begin
          unique case (cond.act)
            pop_pkg::ACT_INIT:    state_nxt = pop_pkg::S_BASE;
            pop_pkg::ACT_ALLOC:   state_nxt = cond.f_nil ? pop_pkg::S_RESP : pop_pkg::S_ALLOC_A;
            pop_pkg::ACT_RELEASE: state_nxt = cond.s_bad ? pop_pkg::S_RESP : pop_pkg::S_LOOKUP;
            pop_pkg::ACT_WALK: begin
              state_nxt = (cond.from_head || cond.s_bad) ? pop_pkg::S_RESP
                                                         : pop_pkg::S_LOOKUP;
            end
            default: state_nxt = pop_pkg::S_RESP;
          endcase
        end
      end
      pop_pkg::S_BASE: begin
        if (cond.base_done) state_nxt = pop_pkg::S_CHECK;
      end
      pop_pkg::S_CHECK: begin
        state_nxt = (cond.over || cond.cnt_zero) ? pop_pkg::S_RESP : pop_pkg::S_FILL;
      end
      pop_pkg::S_FILL: begin
        if (cond.fill_last) state_nxt = pop_pkg::S_RESP;
      end
      pop_pkg::S_ALLOC_A: state_nxt = pop_pkg::S_ALLOC_B;
      pop_pkg::S_ALLOC_B: state_nxt = pop_pkg::S_RESP;
      pop_pkg::S_LOOKUP: begin
        state_nxt = (cond.act == pop_pkg::ACT_RELEASE) ? pop_pkg::S_REL_A : pop_pkg::S_WALK;
      end
      pop_pkg::S_REL_A: begin
        state_nxt = cond.owner_bad ? pop_pkg::S_RESP : pop_pkg::S_REL_B;
      end
      pop_pkg::S_REL_B: state_nxt = pop_pkg::S_RESP;
      pop_pkg::S_WALK:  state_nxt = pop_pkg::S_RESP;
      pop_pkg::S_RESP: begin
        if (cond.out_free) state_nxt = pop_pkg::S_IDLE;
      end
      default: state_nxt = pop_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl           = '0;
    ctl.in_ready  = (state_r == pop_pkg::S_IDLE);
    ctl.capture   = (state_r == pop_pkg::S_IDLE) && cond.in_valid;
    ctl.decode    = (state_r == pop_pkg::S_DECODE);
    ctl.base_step = (state_r == pop_pkg::S_BASE);
    ctl.check     = (state_r == pop_pkg::S_CHECK);
    ctl.fill      = (state_r == pop_pkg::S_FILL);
    ctl.alloc_a   = (state_r == pop_pkg::S_ALLOC_A);
    ctl.alloc_b   = (state_r == pop_pkg::S_ALLOC_B);
    ctl.lookup    = (state_r == pop_pkg::S_LOOKUP);
    ctl.rel_a     = (state_r == pop_pkg::S_REL_A);
    ctl.rel_b     = (state_r == pop_pkg::S_REL_B);
    ctl.walk      = (state_r == pop_pkg::S_WALK);
    ctl.resp_load = (state_r == pop_pkg::S_RESP) && cond.out_free;
  end

endmodule

// ----- tb/tb.sv -----
// Testbench for partitioned_object_pool: directed and random pool actions against
// an in-bench predictor of the free and in-use lists. Depends on pop_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

  localparam int SLOTS = 128;
  localparam int NUM_CLS = 6;
  localparam logic [7:0] NIL = 8'd128;
  localparam int ITEMS_PER_SET = 285;
  localparam int LONG_STALL = 300;

  typedef enum logic [pop_pkg::CFG_IDX_W-1:0] {
    REG_CLASS0_SLOTS, REG_CLASS1_SLOTS, REG_CLASS2_SLOTS,
    REG_CLASS3_SLOTS, REG_CLASS4_SLOTS, REG_CLASS5_SLOTS
  } size_reg_t;

  typedef enum int {SIZES_SMALL, SIZES_FULL, SIZES_WIDE, SIZES_EDGE, SIZES_SKEWED} size_profile_t;

  typedef struct packed {
    logic [pop_pkg::SLOT_IN_W-1:0] slot;
    pop_pkg::stat_t                st;
  } pool_answer_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_action = '0;
  logic [2:0] in_pool_class = '0;
  logic [6:0] in_slot = '0;
  logic       in_from_head = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [6:0] out_result_slot;
  logic [1:0] out_status;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  partitioned_object_pool DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_pool_class(in_pool_class), .in_slot(in_slot), .in_from_head(in_from_head),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_slot(out_result_slot), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // predicted pool state
  logic [7:0]                link_fwd   [SLOTS];
  logic [7:0]                link_back  [SLOTS];
  bit                        slot_taken [SLOTS];
  logic [2:0]                slot_class [SLOTS];
  logic [7:0]                free_top   [NUM_CLS];
  logic [7:0]                inuse_top  [NUM_CLS];
  logic [pop_pkg::CNT_W-1:0] class_size [pop_pkg::REG_COUNT];

  pool_answer_t expected_answers[$];
  int fail_count = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_req = 0;
  int stall_seen = 0;
  int stall_left = 0;

  function automatic void reset_prediction();
    for (int i = 0; i < SLOTS; i++) begin
      link_fwd[i] = '0;
      link_back[i] = '0;
      slot_taken[i] = 1'b0;
      slot_class[i] = '0;
    end
    for (int c = 0; c < NUM_CLS; c++) begin
      free_top[c] = NIL;
      inuse_top[c] = NIL;
    end
    for (int r = 0; r < pop_pkg::REG_COUNT; r++) class_size[r] = pop_pkg::CNT_RESET[r];
  endfunction

  function automatic pool_answer_t predict_pool_action(pop_pkg::act_t a, logic [2:0] c,
                                                       logic [6:0] s, logic fh);
    pool_answer_t r;
    int base;
    int cnt;
    logic [7:0] f, u, p, nx;
    r.slot = '0;
    r.st = pop_pkg::STS_OK;
    if (c >= NUM_CLS) begin
      r.st = pop_pkg::STS_EMPTY;
      return r;
    end
    case (a)
      pop_pkg::ACT_INIT: begin
        base = 0;
        for (int k = 0; k < c; k++) base += class_size[k];
        cnt = class_size[c];
        if (base + cnt > SLOTS) begin
          r.st = pop_pkg::STS_OVER;
        end else begin
          inuse_top[c] = NIL;
          free_top[c] = (cnt > 0) ? 8'(base) : NIL;
          for (int i = 0; i < cnt; i++) begin
            link_fwd[base+i] = (i + 1 < cnt) ? 8'(base + i + 1) : NIL;
            slot_taken[base+i] = 1'b0;
            slot_class[base+i] = c;
          end
        end
      end
      pop_pkg::ACT_ALLOC: begin
        f = free_top[c];
        if (f >= SLOTS) begin
          r.st = pop_pkg::STS_EMPTY;
        end else begin
          free_top[c] = link_fwd[f[6:0]];
          u = inuse_top[c];
          if (u < SLOTS) link_back[u[6:0]] = f;
          link_fwd[f[6:0]] = u;
          link_back[f[6:0]] = NIL;
          inuse_top[c] = f;
          slot_taken[f[6:0]] = 1'b1;
          r.slot = f[6:0];
        end
      end
      pop_pkg::ACT_RELEASE: begin
        if (!slot_taken[s] || slot_class[s] != c) begin
          r.st = pop_pkg::STS_NOT_USED;
        end else begin
          p = link_back[s];
          nx = link_fwd[s];
          if (nx < SLOTS) link_back[nx[6:0]] = p;
          if (p < SLOTS) link_fwd[p[6:0]] = nx;
          else inuse_top[c] = nx;
          link_fwd[s] = free_top[c];
          free_top[c] = {1'b0, s};
          slot_taken[s] = 1'b0;
        end
      end
      default: begin
        if (fh) begin
          u = inuse_top[c];
          if (u >= SLOTS) r.st = pop_pkg::STS_EMPTY;
          else r.slot = u[6:0];
        end else if (!slot_taken[s] || slot_class[s] != c) begin
          r.st = pop_pkg::STS_NOT_USED;
        end else begin
          nx = link_fwd[s];
          if (nx >= SLOTS) r.st = pop_pkg::STS_EMPTY;
          else r.slot = nx[6:0];
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [6:0] pick_busy_slot(logic [2:0] c);
    logic [6:0] hits[$];
    for (int i = 0; i < SLOTS; i++)
      if (slot_taken[i] && slot_class[i] == c) hits.push_back(7'(i));
    if (hits.size() == 0) return 7'($urandom_range(127));
    return hits[$urandom_range(hits.size() - 1)];
  endfunction

  // result side: random backpressure plus an occasional long hold-off
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_req != stall_seen) begin
      out_ready <= 1'b0;
      stall_left <= LONG_STALL;
      stall_seen <= stall_req;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    pool_answer_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected transaction: result_slot %0d status %0d", out_result_slot,
               out_status);
        fail_count++;
      end else begin
        want = expected_answers.pop_front();
        if (out_result_slot !== want.slot) begin
          $error("result_slot: expected %0d, got %0d", want.slot, out_result_slot);
          fail_count++;
        end
        if (out_status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, out_status);
          fail_count++;
        end
      end
    end
  end

  task automatic send_item(pop_pkg::act_t a, logic [2:0] c, logic [6:0] s, logic fh,
                           output pool_answer_t ans);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_action <= a;
    in_pool_class <= c;
    in_slot <= s;
    in_from_head <= fh;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ans = predict_pool_action(a, c, s, fh);
    expected_answers.push_back(ans);
    items_sent++;
  endtask

  task automatic apply_class_sizes(size_profile_t prof);
    logic [pop_pkg::CNT_W-1:0] sz [pop_pkg::REG_COUNT];
    int used;
    in_valid <= 1'b0;
    used = 0;
    for (int i = 0; i < pop_pkg::REG_COUNT; i++) sz[i] = pop_pkg::CNT_RESET[i];
    case (prof)
      SIZES_SMALL:
        for (int i = 0; i < pop_pkg::REG_COUNT; i++) sz[i] = 8'($urandom_range(1, 6));
      SIZES_FULL: begin
        for (int i = 0; i < pop_pkg::REG_COUNT - 1; i++) begin
          sz[i] = 8'($urandom_range(1, 20));
          used += sz[i];
        end
        sz[pop_pkg::REG_COUNT-1] = 8'(SLOTS - used);
      end
      SIZES_WIDE:
        for (int i = 0; i < pop_pkg::REG_COUNT; i++) sz[i] = 8'($urandom_range(1, 40));
      SIZES_EDGE: begin
        sz[0] = 8'd0;
        sz[1] = 8'd128;
        for (int i = 2; i < pop_pkg::REG_COUNT; i++) sz[i] = 8'd1;
      end
      default: begin
        for (int i = 0; i < pop_pkg::REG_COUNT; i++) sz[i] = 8'd0;
        sz[0] = 8'd128;
        sz[3] = 8'd255;
      end
    endcase
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    for (int i = 0; i < pop_pkg::REG_COUNT; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= size_reg_t'(i);
      cfg_data <= sz[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      class_size[i] = sz[i];
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_item();
    pool_answer_t ans;
    logic [2:0] c;
    int roll;
    int steps;
    roll = $urandom_range(99);
    c = 3'($urandom_range(NUM_CLS - 1));
    if (roll < 4) begin
      send_item(pop_pkg::act_t'($urandom_range(3)), 3'($urandom_range(7)),
                7'($urandom_range(127)), 1'($urandom_range(1)), ans);
    end else if (roll < 9) begin
      send_item(pop_pkg::ACT_INIT, c, 7'($urandom_range(127)), 1'($urandom_range(1)), ans);
    end else if (roll < 45) begin
      send_item(pop_pkg::ACT_ALLOC, c, 7'($urandom_range(127)), 1'($urandom_range(1)), ans);
    end else if (roll < 75) begin
      send_item(pop_pkg::ACT_RELEASE, c,
                ($urandom_range(99) < 85) ? pick_busy_slot(c) : 7'($urandom_range(127)),
                1'($urandom_range(1)), ans);
    end else if (roll < 85) begin
      // whole in-use list, head to end
      send_item(pop_pkg::ACT_WALK, c, 7'($urandom_range(127)), 1'b1, ans);
      steps = 0;
      while (ans.st == pop_pkg::STS_OK && steps < SLOTS) begin
        send_item(pop_pkg::ACT_WALK, c, ans.slot, 1'b0, ans);
        steps++;
      end
    end else begin
      send_item(pop_pkg::ACT_WALK, c,
                ($urandom_range(99) < 75) ? pick_busy_slot(c) : 7'($urandom_range(127)),
                1'($urandom_range(3) == 0), ans);
    end
  endtask

  task automatic test_unset_classes();
    pool_answer_t ans;
    send_item(pop_pkg::ACT_ALLOC, 3'd0, 7'd0, 1'b0, ans);
    send_item(pop_pkg::ACT_WALK, 3'd2, 7'd0, 1'b1, ans);
    send_item(pop_pkg::ACT_RELEASE, 3'd1, 7'd0, 1'b0, ans);
    send_item(pop_pkg::ACT_WALK, 3'd5, 7'd127, 1'b0, ans);
    send_item(pop_pkg::ACT_INIT, 3'd6, 7'd0, 1'b0, ans);
    send_item(pop_pkg::ACT_ALLOC, 3'd7, 7'd127, 1'b1, ans);
  endtask

  task automatic test_list_ops();
    pool_answer_t ans;
    send_item(pop_pkg::ACT_INIT, 3'd0, 7'd0, 1'b0, ans);
    repeat (3) send_item(pop_pkg::ACT_ALLOC, 3'd0, 7'd0, 1'b0, ans);
    send_item(pop_pkg::ACT_WALK, 3'd0, 7'd0, 1'b1, ans);
    send_item(pop_pkg::ACT_WALK, 3'd0, 7'd2, 1'b0, ans);
    send_item(pop_pkg::ACT_WALK, 3'd0, 7'd1, 1'b0, ans);
    send_item(pop_pkg::ACT_WALK, 3'd0, 7'd0, 1'b0, ans);
    send_item(pop_pkg::ACT_RELEASE, 3'd0, 7'd1, 1'b0, ans);
    send_item(pop_pkg::ACT_RELEASE, 3'd0, 7'd2, 1'b0, ans);
    send_item(pop_pkg::ACT_RELEASE, 3'd0, 7'd2, 1'b0, ans);
    send_item(pop_pkg::ACT_RELEASE, 3'd1, 7'd0, 1'b0, ans);
    send_item(pop_pkg::ACT_ALLOC, 3'd0, 7'd0, 1'b0, ans);
    send_item(pop_pkg::ACT_INIT, 3'd5, 7'd0, 1'b0, ans);
    send_item(pop_pkg::ACT_ALLOC, 3'd5, 7'd0, 1'b0, ans);
    send_item(pop_pkg::ACT_WALK, 3'd5, 7'd127, 1'b1, ans);
  endtask

  // zero-size class, a class spanning the pool, and classes pushed past the end
  task automatic test_size_extremes();
    pool_answer_t ans;
    apply_class_sizes(SIZES_EDGE);
    send_item(pop_pkg::ACT_INIT, 3'd0, 7'd0, 1'b0, ans);
    send_item(pop_pkg::ACT_ALLOC, 3'd0, 7'd0, 1'b0, ans);
    send_item(pop_pkg::ACT_INIT, 3'd1, 7'd0, 1'b0, ans);
    send_item(pop_pkg::ACT_INIT, 3'd2, 7'd0, 1'b0, ans);
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, size_profile_t prof_a,
                                     size_profile_t prof_b, bit with_stall);
    pool_answer_t ans;
    int stop_at;
    bit stalled;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stalled = 1'b0;
    for (int half = 0; half < 2; half++) begin
      apply_class_sizes(half == 0 ? prof_a : prof_b);
      for (int c = 0; c < NUM_CLS; c++)
        if ($urandom_range(9) < 8)
          send_item(pop_pkg::ACT_INIT, 3'(c), 7'($urandom_range(127)),
                    1'($urandom_range(1)), ans);
      stop_at = items_sent + ITEMS_PER_SET;
      while (items_sent < stop_at) begin
        if (with_stall && !stalled && items_sent >= stop_at - ITEMS_PER_SET / 2) begin
          stall_req++;
          stalled = 1'b1;
        end
        send_random_item();
      end
    end
  endtask

  initial begin
    reset_prediction();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unset_classes();
    test_list_ops();
    test_size_extremes();
    test_random_traffic(29, 56, SIZES_SMALL, SIZES_FULL, 1'b0);
    test_random_traffic(56, 29, SIZES_WIDE, SIZES_SKEWED, 1'b0);
    test_random_traffic(0, 0, SIZES_SMALL, SIZES_FULL, 1'b1);
    in_valid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
